// ===== src/assert_macros.svh =====
// Assertion helpers for the event queue block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, quiet during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/peq_pkg.sv =====
`default_nettype none
package peq_pkg;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned EKEY_W  = 4;
  localparam int unsigned PRIO_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TOTAL_W = 8;

  typedef enum logic [2:0] {
    REQ_ENQ   = 3'd0,
    REQ_DEQ   = 3'd1,
    REQ_ADD   = 3'd2,
    REQ_SET   = 3'd3,
    REQ_TRANS = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_BADPRIO  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_EXISTS   = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [STATE_W-1:0] state_key;
    logic [EKEY_W-1:0]  event_key;
    logic [PRIO_W-1:0]  priority_req;
    logic [DATA_W-1:0]  event_data;
    logic [STATE_W-1:0] next_state;
    logic               has_next;
    logic               has_action;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [STATE_W-1:0] current_state;
    logic [EKEY_W-1:0]  event_key_out;
    logic [DATA_W-1:0]  event_data_out;
    logic               action_fired;
    logic               moved;
    logic [TOTAL_W-1:0] queued_total;
  } out_item_t;
endpackage
`default_nettype wire

// ===== src/peq_front.sv =====
`default_nettype none
// Front: accepts items into a two-entry queue.
module peq_front
  import peq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          q_valid,
  input  wire logic     q_ready,
  output in_item_t      q_item
);
  in_item_t   slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_max, 1'b1, count != 2'd3, "queue count overflow")
  `ASSERT_NEXT(a_push_only, push && !pop && count == 2'd0, count == 2'd1,
    "push not counted")
  `ASSERT_IMPL(a_full_stall, count == 2'd2, !in_ready, "accepting while full")
endmodule
`default_nettype wire

// ===== src/peq_back.sv =====
`default_nettype none
// Back: executes one item per pass through a small sequencer.
module peq_back
  import peq_pkg::*;
#(
  parameter int unsigned NUM_STATES     = 16,
  parameter int unsigned NUM_EVENTS     = 16,
  parameter int unsigned MAX_PRIORITIES = 8,
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned DATA_WIDTH     = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic [3:0] cfg_wdata,
  input  wire logic     q_valid,
  output logic          q_ready,
  input  wire in_item_t q_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);
  localparam int unsigned LW  = (MAX_PRIORITIES > 1) ? $clog2(MAX_PRIORITIES) : 1;
  localparam int unsigned PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW  = $clog2(NUM_STATES);
  localparam int unsigned TD  = NUM_STATES * NUM_EVENTS;
  localparam int unsigned TW  = $clog2(TD);
  localparam int unsigned ED  = MAX_PRIORITIES * QUEUE_DEPTH;
  localparam int unsigned EAW = LW + PW;
  localparam int unsigned EDEPTH = 1 << EAW;
  localparam int unsigned CW  = $clog2(ED + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_LOOK = 5'b00100,
    S_RES  = 5'b01000,
    S_OUT  = 5'b10000
  } st_e;
  st_e st;

  logic [3:0]            qcount;
  logic [STATE_W-1:0]    cur;
  logic [NUM_STATES-1:0] present;
  logic [TD-1:0]         tvalid;
  logic [PW-1:0]         head [MAX_PRIORITIES];
  logic [PW-1:0]         tail [MAX_PRIORITIES];
  logic [FW-1:0]         fill [MAX_PRIORITIES];
  logic [CW-1:0]         total;

  // event store and transition table memories
  logic [EKEY_W+DATA_WIDTH-1:0] ev_mem [EDEPTH];
  logic [EKEY_W+DATA_WIDTH-1:0] ev_rd;
  logic [STATE_W+1:0]           tr_mem [TD];
  logic [STATE_W+1:0]           tr_rd;

  in_item_t   it;
  out_item_t  res;
  out_item_t  rd_res;
  logic          hit;
  logic [LW-1:0] hi_lvl;
  logic          hi_found;
  logic [5:0]    levels;

  always_comb begin
    levels = (32'(qcount) > MAX_PRIORITIES) ? 6'(MAX_PRIORITIES) : {2'b0, qcount};
    hi_found = 1'b0;
    hi_lvl   = '0;
    for (int i = 0; i < MAX_PRIORITIES; i++) begin
      if (6'(i) < levels && fill[i] != '0) begin
        hi_found = 1'b1;
        hi_lvl   = LW'(i);
      end
    end
  end

  logic              ekey_ok, cur_ok;
  logic [TW-1:0]     tidx;
  logic [STATE_W-1:0] tgt;
  logic              tgt_ok;
  logic [EKEY_W-1:0] okey;

  assign okey    = ev_rd[EKEY_W+DATA_WIDTH-1:DATA_WIDTH];
  assign ekey_ok = 32'(okey) < NUM_EVENTS;
  assign cur_ok  = 32'(cur) < NUM_STATES;
  assign tidx    = TW'(32'(cur) * NUM_EVENTS + 32'(okey));
  assign tgt     = tr_rd[STATE_W-1:0];
  assign tgt_ok  = 32'(tgt) < NUM_STATES;

  logic          skey_ok, wkey_ok;
  logic [TW-1:0] widx;
  logic          enq_ok;
  logic [LW-1:0] plvl;

  assign skey_ok = 32'(it.state_key) < NUM_STATES;
  assign wkey_ok = skey_ok && (32'(it.event_key) < NUM_EVENTS);
  assign widx    = TW'(32'(it.state_key) * NUM_EVENTS + 32'(it.event_key));
  assign plvl    = LW'(it.priority_req);
  assign enq_ok  = ({3'b0, it.priority_req} < levels) && (32'(fill[plvl]) < QUEUE_DEPTH);

  assign q_ready   = (st == S_IDLE);
  assign out_valid = (st == S_OUT);
  assign out_item  = res;

  logic [TOTAL_W-1:0] tot8;
  assign tot8 = TOTAL_W'(total);

  // result of the execute cycle; dequeue fields are filled in later
  always_comb begin
    rd_res               = '0;
    rd_res.status        = ST_OK;
    rd_res.current_state = cur;
    rd_res.queued_total  = tot8;
    unique case (it.req_type)
      REQ_ENQ: begin
        if ({3'b0, it.priority_req} >= levels) rd_res.status = ST_BADPRIO;
        else if (!enq_ok) rd_res.status = ST_FULL;
        else rd_res.queued_total = TOTAL_W'(total + 1'b1);
      end
      REQ_DEQ: begin
        if (!hi_found) rd_res.status = ST_EMPTY;
        else rd_res.queued_total = TOTAL_W'(total - 1'b1);
      end
      REQ_ADD: begin
        if (!skey_ok) rd_res.status = ST_NOTFOUND;
        else if (present[SW'(it.state_key)]) rd_res.status = ST_EXISTS;
      end
      REQ_SET: begin
        if (!skey_ok || !present[SW'(it.state_key)]) rd_res.status = ST_NOTFOUND;
        else rd_res.current_state = it.state_key;
      end
      REQ_TRANS: begin
        if (!wkey_ok) rd_res.status = ST_NOTFOUND;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    // memory ports
    ev_rd <= ev_mem[{hi_lvl, head[hi_lvl]}];
    tr_rd <= tr_mem[tidx];
    if (st == S_RD && it.req_type == REQ_ENQ && enq_ok)
      ev_mem[{plvl, tail[plvl]}] <= {it.event_key,
                                     DATA_WIDTH'(it.event_data)};
    if (st == S_RD && it.req_type == REQ_TRANS && wkey_ok)
      tr_mem[widx] <= {it.has_next, it.has_action, it.next_state};
    if (st == S_IDLE && q_valid) it <= q_item;

    if (rst) begin
      st      <= S_IDLE;
      qcount  <= 4'd8;
      cur     <= '0;
      present <= '0;
      tvalid  <= '0;
      total   <= '0;
      hit     <= 1'b0;
      for (int i = 0; i < MAX_PRIORITIES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (cfg_we) qcount <= cfg_wdata;
      unique case (st)
        S_IDLE: if (q_valid) st <= S_RD;
        S_RD: begin
          res <= rd_res;
          st  <= (it.req_type == REQ_DEQ && hi_found) ? S_LOOK : S_OUT;
          unique case (it.req_type)
            REQ_ENQ: if (enq_ok) begin
              tail[plvl] <= (tail[plvl] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail[plvl] + 1'b1;
              fill[plvl] <= fill[plvl] + 1'b1;
              total <= total + 1'b1;
            end
            REQ_DEQ: if (hi_found) begin
              head[hi_lvl] <= (head[hi_lvl] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : head[hi_lvl] + 1'b1;
              fill[hi_lvl] <= fill[hi_lvl] - 1'b1;
              total <= total - 1'b1;
            end
            REQ_ADD: if (skey_ok && !present[SW'(it.state_key)])
              present[SW'(it.state_key)] <= 1'b1;
            REQ_SET: if (skey_ok && present[SW'(it.state_key)]) cur <= it.state_key;
            REQ_TRANS: if (wkey_ok) tvalid[widx] <= 1'b1;
            default: ;
          endcase
        end
        S_LOOK: begin
          // ev_rd holds the event; the table read issues this cycle
          res.event_key_out  <= okey;
          res.event_data_out <= DATA_W'(ev_rd[DATA_WIDTH-1:0]);
          hit <= ekey_ok && cur_ok && tvalid[tidx];
          st  <= S_RES;
        end
        S_RES: begin
          // table data is in tr_rd; the move needs a present target
          res.action_fired <= hit && tr_rd[STATE_W];
          if (hit && tr_rd[STATE_W+1] && tgt_ok && present[SW'(tgt)]) begin
            cur <= tgt;
            res.current_state <= tgt;
            res.moved <= 1'b1;
          end
          st <= S_OUT;
        end
        S_OUT: if (out_ready) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_onehot, 1'b1, $onehot(st), "state not one-hot")
  `ASSERT_IMPL(a_total, 1'b1, 32'(total) <= ED, "queued total overflow")
  `ASSERT_NEXT(a_look_res, st == S_LOOK, st == S_RES, "lookup must lead to resolve")
  `ASSERT_NEXT(a_res_out, st == S_RES, st == S_OUT, "resolve must lead to output")
endmodule
`default_nettype wire

// ===== src/priority_event_queue_fsm.sv =====
`default_nettype none
// Priority event queue state machine.
// Channels: in_valid/in_ready carry one request item (in_item); out_valid/
// out_ready return exactly one result item per request, in order.
// cfg_we/cfg_wdata write queue_count (levels in use) with no handshake;
// write it only while the block is idle.
// Front: a two-entry request queue takes items while the back end works.
// Back: a sequencer runs one request at a time. With the back end idle,
// enqueue, add, set and transition writes pass through pickup and execute
// before their result shows; a dequeue that finds an event passes through
// pickup, execute with the event store read, transition table read, resolve.
// The back sequencer takes no new request until the last result is taken:
// pickup, execute, optional read and resolve, output.
// Reset (rst, synchronous): current state 0, no states present, all
// transitions invalid, all FIFOs empty, queue_count 8. Event and target
// memories are not cleared; valid bits and fills guard them.
// When out_ready is low the result holds in its register and the back end
// waits; the front queue keeps accepting until its two entries are full.
module priority_event_queue_fsm
  import peq_pkg::*;
#(
  parameter int unsigned NUM_STATES     = 16,
  parameter int unsigned NUM_EVENTS     = 16,
  parameter int unsigned MAX_PRIORITIES = 8,
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned DATA_WIDTH     = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_item
);
  logic     q_valid, q_ready;
  in_item_t q_item;

  peq_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  peq_back #(
    .NUM_STATES(NUM_STATES), .NUM_EVENTS(NUM_EVENTS),
    .MAX_PRIORITIES(MAX_PRIORITIES), .QUEUE_DEPTH(QUEUE_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk, .rst, .cfg_we, .cfg_wdata, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_item
  );
endmodule
`default_nettype wire

// ===== tb/priority_event_queue_fsm_tb.sv =====
`timescale 1ns / 1ps
module priority_event_queue_fsm_tb
  import peq_pkg::*;
();

  localparam int NSTATE = 16;
  localparam int NEVENT = 16;
  localparam int NLEVEL = 8;
  localparam int QDEPTH = 16;
  localparam int RANDOM_ITEMS = 1030;
  localparam int CYCLE_LIMIT = 400000;

  // unused request codes, must be ignored by the block
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_NONE      = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  priority_event_queue_fsm i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Shadow copy of the machine: states, transitions, event FIFOs.
  logic [3:0]  lvls_cfg;
  logic [3:0]  fsm_state;
  logic        state_known [NSTATE];
  logic        tr_valid [NSTATE*NEVENT];
  logic        tr_next [NSTATE*NEVENT];
  logic        tr_act [NSTATE*NEVENT];
  logic [3:0]  tr_target [NSTATE*NEVENT];
  logic [3:0]  ev_key [NLEVEL*QDEPTH];
  logic [31:0] ev_data [NLEVEL*QDEPTH];
  int          q_head [NLEVEL];
  int          q_tail [NLEVEL];
  int          q_fill [NLEVEL];

  out_item_t   pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          long_hold = 1'b0;
  bit          stim_done = 1'b0;

  function automatic int levels_active();
    return (lvls_cfg > NLEVEL) ? NLEVEL : int'(lvls_cfg);
  endfunction

  function automatic void shadow_reset();
    lvls_cfg = 4'd8;
    fsm_state = '0;
    foreach (state_known[i]) state_known[i] = 1'b0;
    foreach (tr_valid[i]) tr_valid[i] = 1'b0;
    foreach (q_fill[i]) begin
      q_head[i] = 0; q_tail[i] = 0; q_fill[i] = 0;
    end
  endfunction

  // Computes the result of one request and updates the shadow state.
  function automatic out_item_t process_request(in_item_t r);
    out_item_t o;
    int lvl, slot, idx, tot;
    o = '0;
    o.status = ST_OK;
    case (r.req_type)
      REQ_ENQ: begin
        if (r.priority_req >= levels_active()) o.status = ST_BADPRIO;
        else if (q_fill[r.priority_req] >= QDEPTH) o.status = ST_FULL;
        else begin
          slot = r.priority_req * QDEPTH + q_tail[r.priority_req];
          ev_key[slot] = r.event_key;
          ev_data[slot] = r.event_data;
          q_tail[r.priority_req] = (q_tail[r.priority_req] + 1) % QDEPTH;
          q_fill[r.priority_req]++;
        end
      end
      REQ_DEQ: begin
        lvl = -1;
        for (int i = levels_active() - 1; i >= 0; i--)
          if (lvl < 0 && q_fill[i] != 0) lvl = i;
        if (lvl < 0) o.status = ST_EMPTY;
        else begin
          slot = lvl * QDEPTH + q_head[lvl];
          o.event_key_out = ev_key[slot];
          o.event_data_out = ev_data[slot];
          q_head[lvl] = (q_head[lvl] + 1) % QDEPTH;
          q_fill[lvl]--;
          idx = fsm_state * NEVENT + ev_key[slot];
          if (tr_valid[idx]) begin
            o.action_fired = tr_act[idx];
            if (tr_next[idx] && state_known[tr_target[idx]]) begin
              fsm_state = tr_target[idx];
              o.moved = 1'b1;
            end
          end
        end
      end
      REQ_ADD: begin
        if (state_known[r.state_key]) o.status = ST_EXISTS;
        else state_known[r.state_key] = 1'b1;
      end
      REQ_SET: begin
        if (!state_known[r.state_key]) o.status = ST_NOTFOUND;
        else fsm_state = r.state_key;
      end
      REQ_TRANS: begin
        idx = r.state_key * NEVENT + r.event_key;
        tr_valid[idx] = 1'b1;
        tr_next[idx] = r.has_next;
        tr_act[idx] = r.has_action;
        tr_target[idx] = r.next_state;
      end
      default: ;
    endcase
    tot = 0;
    foreach (q_fill[i]) tot += q_fill[i];
    o.current_state = fsm_state;
    o.queued_total = tot[7:0];
    return o;
  endfunction

  function automatic in_item_t make_req(int kind, int skey, int ekey, int prio,
                                        logic [31:0] data, int nxt, int hn, int ha);
    in_item_t r;
    r.req_type = 3'(kind); r.state_key = 4'(skey); r.event_key = 4'(ekey);
    r.priority_req = 3'(prio); r.event_data = data; r.next_state = 4'(nxt);
    r.has_next = (hn != 0); r.has_action = (ha != 0);
    return r;
  endfunction

  // Random request, weighted toward enqueue and dequeue.
  function automatic in_item_t random_req();
    in_item_t r;
    int pick;
    r.state_key = 4'($urandom_range(0, 15));
    r.event_key = 4'($urandom_range(0, 15));
    r.priority_req = 3'($urandom_range(0, 7));
    r.event_data = $urandom;
    r.next_state = 4'($urandom_range(0, 15));
    r.has_next = 1'($urandom);
    r.has_action = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) r.req_type = REQ_ENQ;
    else if (pick < 70) r.req_type = REQ_DEQ;
    else if (pick < 78) r.req_type = REQ_ADD;
    else if (pick < 85) r.req_type = REQ_SET;
    else if (pick < 98) r.req_type = REQ_TRANS;
    else r.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    return r;
  endfunction

  // Sender: holds valid until accepted; random bursts and gaps.
  task automatic send_req(in_item_t r);
    in_valid <= 1'b1;
    in_item <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(process_request(r));
  endtask

  task automatic send_gap();
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_then_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_levels(logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lvls_cfg = v;
  endtask

  // Receiver: own stall pattern, plus one long hold-off.
  always @(posedge clk) begin
    if (long_hold) out_ready <= 1'b0;
    else out_ready <= (cycles % 11 < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %p act %p", want, out_item);
        end
      end
    end
  end

  typedef struct {
    in_item_t req;
    bit       typed;
    out_item_t res;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic void add_row(in_item_t r, int typed, int st, int cs, int tot);
    stim_row_t s;
    s.req = r; s.typed = (typed != 0); s.res = '0;
    s.res.status = 3'(st); s.res.current_state = 4'(cs); s.res.queued_total = 8'(tot);
    dir_rows.push_back(s);
  endfunction

  initial begin
    out_item_t typed_res;
    shadow_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: the easy rows carry their result typed in.
    add_row(make_req(REQ_DEQ, 0, 0, 0, 0, 0, 0, 0), 1, ST_EMPTY, 0, 0);
    add_row(make_req(REQ_SET, 3, 0, 0, 0, 0, 0, 0), 1, ST_NOTFOUND, 0, 0);
    add_row(make_req(REQ_ADD, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0, 0);
    add_row(make_req(REQ_ADD, 15, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0, 0);
    add_row(make_req(REQ_ADD, 15, 0, 0, 0, 0, 0, 0), 1, ST_EXISTS, 0, 0);
    add_row(make_req(REQ_TRANS, 0, 15, 0, 0, 15, 1, 1), 1, ST_OK, 0, 0);
    add_row(make_req(REQ_TRANS, 15, 0, 0, 0, 9, 1, 1), 1, ST_OK, 0, 0);   // target absent
    add_row(make_req(REQ_TRANS, 15, 1, 0, 0, 15, 1, 0), 1, ST_OK, 0, 0);  // self move
    add_row(make_req(REQ_TRANS, 15, 2, 0, 0, 0, 0, 1), 1, ST_OK, 0, 0);   // action only
    add_row(make_req(REQ_ENQ, 0, 15, 0, 32'h0, 0, 0, 0), 1, ST_OK, 0, 1);
    add_row(make_req(REQ_ENQ, 0, 0, 7, 32'hFFFF_FFFF, 0, 0, 0), 1, ST_OK, 0, 2);
    add_row(make_req(REQ_ENQ, 0, 1, 7, 32'hA5A5_5A5A, 0, 0, 0), 1, ST_OK, 0, 3);
    add_row(make_req(REQ_ENQ, 0, 2, 3, 32'h1234_5678, 0, 0, 0), 1, ST_OK, 0, 4);
    add_row(make_req(REQ_ENQ, 0, 7, 1, 32'h8000_0001, 0, 0, 0), 1, ST_OK, 0, 5);
    for (int i = 0; i < 6; i++) add_row(make_req(REQ_DEQ, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(make_req(REQ_SET, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(make_req(REQ_UNUSED_LO, 15, 15, 7, 32'hFFFF_FFFF, 15, 1, 1), 0, 0, 0, 0);
    add_row(make_req(REQ_NONE, 3, 4, 5, 32'h0000_0001, 6, 1, 0), 0, 0, 0, 0);
    add_row(make_req(REQ_UNUSED_HI, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        // where the shadow and the hand-typed row differ, the typed row is expected
        typed_res = dir_rows[i].res;
        send_req(dir_rows[i].req);
        if (pending_results[$] !== typed_res) begin
          pending_results[$] = typed_res;
        end
      end else send_req(dir_rows[i].req);
    end
    drain_then_idle();

    // Full queue: 16 fit, the 17th reports full; then bad priority at two levels.
    for (int i = 0; i < QDEPTH + 1; i++)
      send_req(make_req(REQ_ENQ, 0, i, 2, $urandom, 0, 0, 0));
    drain_then_idle();
    write_levels(4'd2);
    send_req(make_req(REQ_ENQ, 0, 3, 2, 1, 0, 0, 0));
    drain_then_idle();
    write_levels(4'd0);
    send_req(make_req(REQ_ENQ, 0, 3, 0, 1, 0, 0, 0));
    send_req(make_req(REQ_DEQ, 0, 0, 0, 0, 0, 0, 0));
    drain_then_idle();
    write_levels(4'd15);

    // Random phases across register settings, with one long receiver hold-off.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 1) fork
        begin
          long_hold = 1'b1;
          repeat (300) @(posedge clk);
          long_hold = 1'b0;
        end
      join_none
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
        send_req(random_req());
        send_gap();
      end
      drain_then_idle();
      case (ph)
        0: write_levels(4'd1);
        1: write_levels(4'd8);
        2: write_levels(4'd4);
        3: write_levels(4'd3);
        default: ;
      endcase
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end
endmodule
